FILE: rtl/bbcc_pkg.sv
// Shared types and constants for the bounding box cut crossing cost block.
package bbcc_pkg;

	localparam int IN_COORD_W  = 12;  // width of one box coordinate on the port
	localparam int IN_DATA_W   = 4 * IN_COORD_W;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_INDEX_W = 3;
	localparam int INV_W       = 17;
	localparam int SPAN_W      = 13;  // max - min + 1 for the widest coordinate
	localparam int SUM_W       = 15;  // sum of up to four spans
	localparam int WEIGHT_W    = 32;  // SUM_W x INV_W product
	localparam int CNT_W       = 3;
	localparam int TERM_W      = 35;  // CNT_W x WEIGHT_W product
	localparam int TOTAL_W     = 36;
	localparam int COST_W      = 32;
	localparam int OUT_DATA_W  = 40;  // 39 bits of fields, padded to whole bytes

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COST_MODE      = 3'd0,
		REG_INV_GRID_W     = 3'd1,
		REG_INV_GRID_H     = 3'd2,
		REG_ROW_CUT_POS    = 3'd3,
		REG_COL_CUT_POS    = 3'd4,
		REG_ROW_CUT_MINSEG = 3'd5,
		REG_COL_CUT_MINSEG = 3'd6
	} reg_idx_t;

	// Settings that one cut direction needs.
	typedef struct packed {
		logic                  mode;
		logic [INV_W-1:0]      inv;
		logic [CFG_DATA_W-1:0] positions;
		logic [CFG_DATA_W-1:0] segments;
	} dir_cfg_t;

endpackage

FILE: rtl/bbcc_dir.sv
// Cut scan and weighting for one direction: stages two to four of the pipeline.
module bbcc_dir
	import bbcc_pkg::*;
#(
	parameter int MAX_CUTS   = 4,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  en,
	input  dir_cfg_t              cfg,
	input  logic [COORD_BITS-1:0] lo_s1,
	input  logic [COORD_BITS-1:0] hi_s1,
	output logic [CNT_W-1:0]      count_s4,
	output logic [WEIGHT_W-1:0]   weight_s4
);

	logic [MAX_CUTS-1:0] cross_c;
	logic [SPAN_W-1:0]   span_c;
	logic [SPAN_W-1:0]   diff_c [MAX_CUTS];

	logic [MAX_CUTS-1:0] cross_s2;
	logic [SPAN_W-1:0]   span_s2;
	logic [SPAN_W-1:0]   diff_s2 [MAX_CUTS];

	logic [CNT_W-1:0]    count_c;
	logic [SUM_W-1:0]    sum_c;

	logic [CNT_W-1:0]    count_s3;
	logic [SUM_W-1:0]    base_s3;

	assign span_c = SPAN_W'(hi_s1) - SPAN_W'(lo_s1) + SPAN_W'(1);

	for (genvar i = 0; i < MAX_CUTS; i++) begin : g_slot
		logic [COORD_BITS-1:0] pos;
		logic [SPAN_W-1:0]     seg;
		assign pos = cfg.positions[i*COORD_BITS +: COORD_BITS];
		assign seg = SPAN_W'(cfg.segments[i*COORD_BITS +: COORD_BITS]);
		// all ones marks an unused slot
		assign cross_c[i] = !(&pos) && (pos >= lo_s1) && (pos < hi_s1);
		always_comb begin
			if (!cross_c[i]) begin
				diff_c[i] = '0;
			end else if (seg >= span_c) begin
				diff_c[i] = seg - span_c;
			end else begin
				diff_c[i] = span_c - seg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s2 <= cross_c;
			span_s2  <= span_c;
			diff_s2  <= diff_c;
		end
	end

	always_comb begin
		count_c = '0;
		sum_c   = '0;
		for (int i = 0; i < MAX_CUTS; i++) begin
			count_c = count_c + CNT_W'(cross_s2[i]);
			sum_c   = sum_c + SUM_W'(diff_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s3 <= count_c;
			base_s3  <= cfg.mode ? sum_c : SUM_W'(span_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s4  <= count_s3;
			weight_s4 <= WEIGHT_W'(base_s3) * WEIGHT_W'(cfg.inv);
		end
	end

endmodule

FILE: rtl/bbox_cut_crossing_cost.sv
// Top level of the bounding box cut crossing cost pipeline.
// Takes one net bounding box per cycle. Its cut crossing counts and Q16.16 cost
// appear on m_axis once the item has passed five registers: input register, slot
// compare, count and sum, weight multiply, and combine and saturate into the
// output register. Throughput is one item per clock; s_axis_tready drops only
// while the output register holds an item that m_axis_tready does not take, and
// the whole pipeline then holds. Configuration is to be written through
// cfg_we/cfg_index/cfg_wdata while no item is in flight; the block itself does not
// enforce this. Writes to indexes beyond the register list are ignored.
module bbox_cut_crossing_cost
	import bbcc_pkg::*;
#(
	parameter int MAX_CUTS   = 4,
	parameter int COORD_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// box_x_min, box_x_max, box_y_min, box_y_max (12 bits each)
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// crossing_cost[31:0], row_crossings[34:32], column_crossings[37:35],
	// crosses_any[38], zero pad[39]
	output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

	logic                  mode_q;
	logic [INV_W-1:0]      inv_w_q;
	logic [INV_W-1:0]      inv_h_q;
	logic [CFG_DATA_W-1:0] row_pos_q;
	logic [CFG_DATA_W-1:0] col_pos_q;
	logic [CFG_DATA_W-1:0] row_seg_q;
	logic [CFG_DATA_W-1:0] col_seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			inv_w_q   <= INV_W'(16);
			inv_h_q   <= INV_W'(16);
			row_pos_q <= '1;
			col_pos_q <= '1;
			row_seg_q <= '0;
			col_seg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COST_MODE:      mode_q    <= cfg_wdata[0];
				REG_INV_GRID_W:     inv_w_q   <= cfg_wdata[INV_W-1:0];
				REG_INV_GRID_H:     inv_h_q   <= cfg_wdata[INV_W-1:0];
				REG_ROW_CUT_POS:    row_pos_q <= cfg_wdata;
				REG_COL_CUT_POS:    col_pos_q <= cfg_wdata;
				REG_ROW_CUT_MINSEG: row_seg_q <= cfg_wdata;
				REG_COL_CUT_MINSEG: col_seg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance: everything moves unless the output item is stuck
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_s1          <= s_axis_tvalid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			v_s4          <= v_s3;
			m_axis_tvalid <= v_s4;
		end
	end

	logic [COORD_BITS-1:0] x_min_s1, x_max_s1, y_min_s1, y_max_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_min_s1 <= s_axis_tdata[0*IN_COORD_W +: COORD_BITS];
			x_max_s1 <= s_axis_tdata[1*IN_COORD_W +: COORD_BITS];
			y_min_s1 <= s_axis_tdata[2*IN_COORD_W +: COORD_BITS];
			y_max_s1 <= s_axis_tdata[3*IN_COORD_W +: COORD_BITS];
		end
	end

	dir_cfg_t row_cfg, col_cfg;
	assign row_cfg = '{mode: mode_q, inv: inv_h_q, positions: row_pos_q, segments: row_seg_q};
	assign col_cfg = '{mode: mode_q, inv: inv_w_q, positions: col_pos_q, segments: col_seg_q};

	logic [CNT_W-1:0]    row_cnt_s4, col_cnt_s4;
	logic [WEIGHT_W-1:0] row_w_s4, col_w_s4;

	bbcc_dir #(.MAX_CUTS(MAX_CUTS), .COORD_BITS(COORD_BITS)) u_row (
		.clk      (clk),
		.en       (en),
		.cfg      (row_cfg),
		.lo_s1    (y_min_s1),
		.hi_s1    (y_max_s1),
		.count_s4 (row_cnt_s4),
		.weight_s4(row_w_s4)
	);

	bbcc_dir #(.MAX_CUTS(MAX_CUTS), .COORD_BITS(COORD_BITS)) u_col (
		.clk      (clk),
		.en       (en),
		.cfg      (col_cfg),
		.lo_s1    (x_min_s1),
		.hi_s1    (x_max_s1),
		.count_s4 (col_cnt_s4),
		.weight_s4(col_w_s4)
	);

	// a zero count zeroes its term, so no crossing gives zero cost
	logic [TERM_W-1:0]  row_term, col_term;
	logic [TOTAL_W-1:0] total;
	logic [COST_W-1:0]  cost;

	assign row_term = TERM_W'(row_cnt_s4) * TERM_W'(row_w_s4);
	assign col_term = TERM_W'(col_cnt_s4) * TERM_W'(col_w_s4);
	assign total    = TOTAL_W'(row_term) + TOTAL_W'(col_term);
	assign cost     = (|total[TOTAL_W-1:COST_W]) ? '1 : total[COST_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {1'b0,
			                 (|row_cnt_s4) || (|col_cnt_s4),
			                 col_cnt_s4,
			                 row_cnt_s4,
			                 cost};
		end
	end

`ifndef SYNTHESIS
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a blocked output item");

	a_any_matches_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[38] == ((m_axis_tdata[34:32] != '0) ||
		                                         (m_axis_tdata[37:35] != '0))))
		else $error("crosses_any disagrees with the counts");

	a_no_cross_no_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[38]) |-> (m_axis_tdata[31:0] == '0))
		else $error("cost reported for a box that crosses nothing");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[34:32] <= CNT_W'(MAX_CUTS)) &&
		                   (m_axis_tdata[37:35] <= CNT_W'(MAX_CUTS))))
		else $error("crossing count above the number of cut slots");
`endif

endmodule
